/* design/bgbl_pkg.sv */
// ----------------------------------------------------------------------------
// bgbl_pkg: shared types and constants of the beam gain lookup
// Operation codes, fixed field widths and the control word that travels
// with every pipeline stage.
// ----------------------------------------------------------------------------
package bgbl_pkg;

  localparam int OP_W        = 2;
  localparam int PHI_IDX_W   = 12;
  localparam int THETA_IDX_W = 7;
  localparam int COMP_W      = 16;
  localparam int THETA_W     = 22;
  localparam int PHI_W       = 23;
  localparam int GAIN_W      = 33;
  localparam int SQ_W        = 32;
  localparam int PHI_ADJ_W   = 33;

  localparam logic [OP_W-1:0] OP_WR_H   = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_V   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // Control word carried alongside the data of each stage.
  typedef struct packed {
    logic valid;
    logic lookup;
    logic write;
    logic grid_v;
    logic in_range;
  } ctl_t;

endpackage

/* design/bgbl_if.sv */
// ----------------------------------------------------------------------------
// bgbl_if: valid/ready channels of the beam gain lookup
// One interface for the input words and one for the result words.
// ----------------------------------------------------------------------------
interface bgbl_in_if import bgbl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               op;
  logic [PHI_IDX_W-1:0]          cell_phi_index;
  logic [THETA_IDX_W-1:0]        cell_theta_index;
  logic signed [COMP_W-1:0]      component_one;
  logic signed [COMP_W-1:0]      component_two;
  logic signed [COMP_W-1:0]      component_three;
  logic signed [COMP_W-1:0]      component_four;
  logic signed [THETA_W-1:0]     theta_angle;
  logic signed [PHI_W-1:0]       phi_angle;

  modport source (output valid, op, cell_phi_index, cell_theta_index, component_one,
                  component_two, component_three, component_four, theta_angle,
                  phi_angle, input ready);
  modport sink (input valid, op, cell_phi_index, cell_theta_index, component_one,
                component_two, component_three, component_four, theta_angle,
                phi_angle, output ready);
endinterface

interface bgbl_out_if import bgbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain_horizontal;
  logic [GAIN_W-1:0] gain_vertical;
  logic              in_range;

  modport source (output valid, gain_horizontal, gain_vertical, in_range, input ready);
  modport sink (input valid, gain_horizontal, gain_vertical, in_range, output ready);
endinterface

/* design/bgbl_prep.sv */
// ----------------------------------------------------------------------------
// bgbl_prep: front end of the lookup pipeline
// Squares and sums the write components, folds negative phi, checks the
// grid bounds and forms the four banked addresses, over three stages.
// ----------------------------------------------------------------------------
module bgbl_prep import bgbl_pkg::*; #(
  parameter int THETA_CELLS   = 128,
  parameter int PHI_CELLS     = 4096,
  parameter int FRACTION_BITS = 10,
  parameter int RB            = 11,
  parameter int CB            = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       accept,
  input  logic [OP_W-1:0]            op,
  input  logic [PHI_IDX_W-1:0]       cell_phi_index,
  input  logic [THETA_IDX_W-1:0]     cell_theta_index,
  input  logic signed [COMP_W-1:0]   component_one,
  input  logic signed [COMP_W-1:0]   component_two,
  input  logic signed [COMP_W-1:0]   component_three,
  input  logic signed [COMP_W-1:0]   component_four,
  input  logic signed [THETA_W-1:0]  theta_angle,
  input  logic signed [PHI_W-1:0]    phi_angle,
  output ctl_t                       s3_ctl,
  output logic [1:0]                 s3_wr_bank,
  output logic [RB+CB-1:0]           s3_wr_addr,
  output logic [GAIN_W-1:0]          s3_wr_data,
  output logic [3:0][RB+CB-1:0]      s3_rd_addr,
  output logic                       s3_ip0,
  output logic                       s3_it0,
  output logic [FRACTION_BITS-1:0]   s3_ft,
  output logic [FRACTION_BITS-1:0]   s3_fp
);

  localparam int F   = FRACTION_BITS;
  localparam int AB  = RB + CB;
  localparam int ITW = THETA_W - F;
  localparam int IPW = PHI_ADJ_W - 1 - F;
  localparam longint PHI_WRAP_L = 64'd3600 * (64'd1 << F);
  localparam logic signed [PHI_ADJ_W-1:0] PHI_WRAP = PHI_ADJ_W'(PHI_WRAP_L);

  // Stage 1
  ctl_t                        s1_ctl_r;
  logic [3:0][SQ_W-1:0]        s1_sq_r;
  logic [PHI_IDX_W-1:0]        s1_pi_r;
  logic [THETA_IDX_W-1:0]      s1_ti_r;
  logic signed [THETA_W-1:0]   s1_theta_r;
  logic signed [PHI_ADJ_W-1:0] s1_phi_r;
  logic signed [PHI_ADJ_W-1:0] phi_ext;
  logic signed [PHI_ADJ_W-1:0] s1_phi_nxt;
  logic signed [SQ_W-1:0]      sq1, sq2, sq3, sq4;

  // Stage 2
  ctl_t                        s2_ctl_r;
  ctl_t                        s2_ctl_nxt;
  logic [SQ_W:0]               s2_ps0_r, s2_ps1_r;
  logic [1:0]                  s2_wbank_r;
  logic [AB-1:0]               s2_waddr_r;
  logic [ITW-1:0]              s2_it_r;
  logic [IPW-1:0]              s2_ip_r;
  logic [F-1:0]                s2_ft_r, s2_fp_r;
  logic [ITW-1:0]              it_w;
  logic [IPW-1:0]              ip_w;
  logic [31:0]                 wrow, wcol;

  // Stage 3
  logic [3:0][AB-1:0]          s3_rd_addr_nxt;
  logic [31:0]                 rrow, rcol;

  assign sq1 = component_one * component_one;
  assign sq2 = component_two * component_two;
  assign sq3 = component_three * component_three;
  assign sq4 = component_four * component_four;
  assign phi_ext = PHI_ADJ_W'(phi_angle);
  assign s1_phi_nxt = phi_angle[PHI_W-1] ? phi_ext + PHI_WRAP : phi_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r.valid    <= accept && (op != OP_NOP);
      s1_ctl_r.lookup   <= (op == OP_LOOKUP);
      s1_ctl_r.write    <= (op == OP_WR_H) || (op == OP_WR_V);
      s1_ctl_r.grid_v   <= (op == OP_WR_V);
      s1_ctl_r.in_range <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sq_r    <= {sq4, sq3, sq2, sq1};
      s1_pi_r    <= cell_phi_index;
      s1_ti_r    <= cell_theta_index;
      s1_theta_r <= theta_angle;
      s1_phi_r   <= s1_phi_nxt;
    end
  end

  // Grid indexes and bounds.
  assign it_w = s1_theta_r[THETA_W-1:F];
  assign ip_w = s1_phi_r[PHI_ADJ_W-2:F];
  assign wrow = 32'(s1_pi_r) >> 1;
  assign wcol = 32'(s1_ti_r) >> 1;

  always_comb begin
    s2_ctl_nxt       = s1_ctl_r;
    s2_ctl_nxt.write = s1_ctl_r.write && (32'(s1_pi_r) < 32'(PHI_CELLS)) &&
                       (32'(s1_ti_r) < 32'(THETA_CELLS));
    s2_ctl_nxt.in_range = !s1_theta_r[THETA_W-1] && !s1_phi_r[PHI_ADJ_W-1] &&
                          (32'(it_w) + 32'd1 < 32'(THETA_CELLS)) &&
                          (32'(ip_w) + 32'd1 < 32'(PHI_CELLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s2_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ps0_r   <= {1'b0, s1_sq_r[0]} + {1'b0, s1_sq_r[1]};
      s2_ps1_r   <= {1'b0, s1_sq_r[2]} + {1'b0, s1_sq_r[3]};
      s2_wbank_r <= {s1_pi_r[0], s1_ti_r[0]};
      s2_waddr_r <= {wrow[RB-1:0], wcol[CB-1:0]};
      s2_it_r    <= it_w;
      s2_ip_r    <= ip_w;
      s2_ft_r    <= s1_theta_r[F-1:0];
      s2_fp_r    <= s1_phi_r[F-1:0];
    end
  end

  // Bank k = {phi parity, theta parity} holds the neighbor whose indexes
  // have those parities.
  always_comb begin
    s3_rd_addr_nxt = '0;
    rrow = '0;
    rcol = '0;
    for (int k = 0; k < 4; k++) begin
      rrow = (32'(s2_ip_r) + 32'(s2_ip_r[0] ^ k[1])) >> 1;
      rcol = (32'(s2_it_r) + 32'(s2_it_r[0] ^ k[0])) >> 1;
      s3_rd_addr_nxt[k] = {rrow[RB-1:0], rcol[CB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl <= '0;
    end else if (adv) begin
      s3_ctl <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_wr_bank <= s2_wbank_r;
      s3_wr_addr <= s2_waddr_r;
      s3_wr_data <= GAIN_W'({1'b0, s2_ps0_r} + {1'b0, s2_ps1_r});
      s3_rd_addr <= s3_rd_addr_nxt;
      s3_ip0     <= s2_ip_r[0];
      s3_it0     <= s2_it_r[0];
      s3_ft      <= s2_ft_r;
      s3_fp      <= s2_fp_r;
    end
  end

endmodule

/* design/bgbl_bank.sv */
// ----------------------------------------------------------------------------
// bgbl_bank: one bank of a gain grid
// Single write port and single read port with registered read data; both
// move only when the pipeline advances.
// ----------------------------------------------------------------------------
module bgbl_bank import bgbl_pkg::*; #(
  parameter int AB = 17
) (
  input  logic              clk,
  input  logic              adv,
  input  logic              we,
  input  logic [AB-1:0]     waddr,
  input  logic [GAIN_W-1:0] wdata,
  input  logic [AB-1:0]     raddr,
  output logic [GAIN_W-1:0] rdata_r
);

  logic [GAIN_W-1:0] mem [2**AB];

  always_ff @(posedge clk) begin
    if (adv && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* design/bgbl_interp.sv */
// ----------------------------------------------------------------------------
// bgbl_interp: bilinear blend of both grids
// Theta blend over two stages, phi blend over two more, the last one
// being the output register.
// ----------------------------------------------------------------------------
module bgbl_interp import bgbl_pkg::*; #(
  parameter int FRACTION_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  ctl_t                     s4_ctl,
  input  logic [3:0][GAIN_W-1:0]   rd_h,
  input  logic [3:0][GAIN_W-1:0]   rd_v,
  input  logic                     s4_ip0,
  input  logic                     s4_it0,
  input  logic [FRACTION_BITS-1:0] s4_ft,
  input  logic [FRACTION_BITS-1:0] s4_fp,
  output logic                     out_valid_r,
  output logic [GAIN_W-1:0]        gain_h_r,
  output logic [GAIN_W-1:0]        gain_v_r,
  output logic                     in_range_r
);

  localparam int F  = FRACTION_BITS;
  localparam int PW = GAIN_W + F + 1;

  logic [F:0]                wt_t0, wt_t1, wt_p0, wt_p1;
  logic [3:0][GAIN_W-1:0]    nb_h, nb_v;
  logic [1:0]                sel;

  logic [2:0]                vld_r;
  logic [2:0]                rng_r;
  logic [3:0][PW-1:0]        s5_ph_r, s5_pv_r;
  logic [F-1:0]              s5_fp_r, s6_fp_r;
  logic [1:0][GAIN_W-1:0]    s6_gh_r, s6_gv_r;
  logic [1:0][PW-1:0]        s7_qh_r, s7_qv_r;
  logic [PW:0]               sum_h, sum_v;

  assign wt_t1 = {1'b0, s4_ft};
  assign wt_t0 = {1'b1, {F{1'b0}}} - wt_t1;
  assign wt_p1 = {1'b0, s6_fp_r};
  assign wt_p0 = {1'b1, {F{1'b0}}} - wt_p1;

  // Neighbor n = {phi step, theta step} sits in bank n xor the parities.
  always_comb begin
    nb_h = '0;
    nb_v = '0;
    sel  = '0;
    for (int n = 0; n < 4; n++) begin
      sel     = 2'(n) ^ {s4_ip0, s4_it0};
      nb_h[n] = rd_h[sel];
      nb_v[n] = rd_v[sel];
    end
  end

  // Bit i of the valid and range shifts travels with stage five plus i.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], s4_ctl.valid && s4_ctl.lookup};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rng_r <= {rng_r[1:0], s4_ctl.in_range};
      for (int n = 0; n < 4; n++) begin
        s5_ph_r[n] <= PW'(nb_h[n] * (n[0] ? wt_t1 : wt_t0));
        s5_pv_r[n] <= PW'(nb_v[n] * (n[0] ? wt_t1 : wt_t0));
      end
      s5_fp_r <= s4_fp;
      s6_fp_r <= s5_fp_r;
      for (int r = 0; r < 2; r++) begin
        s6_gh_r[r] <= GAIN_W'(({1'b0, s5_ph_r[2*r]} + {1'b0, s5_ph_r[2*r+1]}) >> F);
        s6_gv_r[r] <= GAIN_W'(({1'b0, s5_pv_r[2*r]} + {1'b0, s5_pv_r[2*r+1]}) >> F);
      end
      s7_qh_r[0] <= PW'(s6_gh_r[0] * wt_p0);
      s7_qh_r[1] <= PW'(s6_gh_r[1] * wt_p1);
      s7_qv_r[0] <= PW'(s6_gv_r[0] * wt_p0);
      s7_qv_r[1] <= PW'(s6_gv_r[1] * wt_p1);
    end
  end

  assign sum_h = {1'b0, s7_qh_r[0]} + {1'b0, s7_qh_r[1]};
  assign sum_v = {1'b0, s7_qv_r[0]} + {1'b0, s7_qv_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_range_r <= rng_r[2];
      gain_h_r   <= rng_r[2] ? sum_h[F+GAIN_W-1:F] : '0;
      gain_v_r   <= rng_r[2] ? sum_v[F+GAIN_W-1:F] : '0;
    end
  end

endmodule

/* design/beam_gain_bilinear_lookup_top.sv */
// ----------------------------------------------------------------------------
// beam_gain_bilinear_lookup_top: banked bilinear antenna gain lookup
// Stores horizontal and vertical gain grids and interpolates both between
// the four cells around a theta/phi point.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  in_chan   in   op, cell indexes, four components, theta and phi angles
//  out_chan  out  both interpolated gains and the in-range flag
//
// One word is accepted every cycle while the pipeline advances. A lookup's
// result word comes from the output register behind stage seven; writes and
// no-op words give no result. Each grid is split into four banks by phi and
// theta parity, so the four neighbors come out of four different banks at once.
// Writes and reads both hit the banks in stage four, so a lookup sees every
// write accepted before it. The whole pipeline stalls together while a
// result word waits on out_chan.ready; nothing is dropped or repeated.
// Reset clears only the control words and valid bits; the grids are not cleared.
module beam_gain_bilinear_lookup_top import bgbl_pkg::*; #(
  parameter int THETA_CELLS   = 128,
  parameter int PHI_CELLS     = 4096,
  parameter int FRACTION_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  bgbl_in_if.sink    in_chan,
  bgbl_out_if.source out_chan
);

  localparam int RB_RAW = $clog2((PHI_CELLS + 1) / 2);
  localparam int CB_RAW = $clog2((THETA_CELLS + 1) / 2);
  localparam int RB     = (RB_RAW < 1) ? 1 : RB_RAW;
  localparam int CB     = (CB_RAW < 1) ? 1 : CB_RAW;
  localparam int AB     = RB + CB;

  logic                     adv;
  logic                     accept;
  ctl_t                     s3_ctl;
  ctl_t                     s4_ctl_r;
  logic [1:0]               s3_wr_bank;
  logic [AB-1:0]            s3_wr_addr;
  logic [GAIN_W-1:0]        s3_wr_data;
  logic [3:0][AB-1:0]       s3_rd_addr;
  logic                     s3_ip0, s3_it0, s4_ip0_r, s4_it0_r;
  logic [FRACTION_BITS-1:0] s3_ft, s3_fp, s4_ft_r, s4_fp_r;
  logic [3:0][GAIN_W-1:0]   rd_h, rd_v;
  logic                     out_valid;

  // The pipeline moves as a whole whenever the output register can take a word.
  assign adv           = !out_valid || out_chan.ready;
  assign accept        = in_chan.valid && adv;
  assign in_chan.ready = adv;
  assign out_chan.valid = out_valid;

  bgbl_prep #(
    .THETA_CELLS(THETA_CELLS), .PHI_CELLS(PHI_CELLS),
    .FRACTION_BITS(FRACTION_BITS), .RB(RB), .CB(CB)
  ) u_prep (
    .clk, .rst_n, .adv, .accept,
    .op(in_chan.op),
    .cell_phi_index(in_chan.cell_phi_index),
    .cell_theta_index(in_chan.cell_theta_index),
    .component_one(in_chan.component_one),
    .component_two(in_chan.component_two),
    .component_three(in_chan.component_three),
    .component_four(in_chan.component_four),
    .theta_angle(in_chan.theta_angle),
    .phi_angle(in_chan.phi_angle),
    .s3_ctl, .s3_wr_bank, .s3_wr_addr, .s3_wr_data, .s3_rd_addr,
    .s3_ip0, .s3_it0, .s3_ft, .s3_fp
  );

  // Stage four: bank access, with the control word riding alongside.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    bgbl_bank #(.AB(AB)) u_bank_h (
      .clk, .adv,
      .we(s3_ctl.valid && s3_ctl.write && !s3_ctl.grid_v && (s3_wr_bank == 2'(k))),
      .waddr(s3_wr_addr), .wdata(s3_wr_data),
      .raddr(s3_rd_addr[k]), .rdata_r(rd_h[k])
    );
    bgbl_bank #(.AB(AB)) u_bank_v (
      .clk, .adv,
      .we(s3_ctl.valid && s3_ctl.write && s3_ctl.grid_v && (s3_wr_bank == 2'(k))),
      .waddr(s3_wr_addr), .wdata(s3_wr_data),
      .raddr(s3_rd_addr[k]), .rdata_r(rd_v[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (adv) begin
      s4_ctl_r <= s3_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ip0_r <= s3_ip0;
      s4_it0_r <= s3_it0;
      s4_ft_r  <= s3_ft;
      s4_fp_r  <= s3_fp;
    end
  end

  bgbl_interp #(.FRACTION_BITS(FRACTION_BITS)) u_interp (
    .clk, .rst_n, .adv,
    .s4_ctl(s4_ctl_r), .rd_h, .rd_v,
    .s4_ip0(s4_ip0_r), .s4_it0(s4_it0_r), .s4_ft(s4_ft_r), .s4_fp(s4_fp_r),
    .out_valid_r(out_valid),
    .gain_h_r(out_chan.gain_horizontal),
    .gain_v_r(out_chan.gain_vertical),
    .in_range_r(out_chan.in_range)
  );

  // An out-of-range lookup must report zero gains.
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chan.in_range |->
      (out_chan.gain_horizontal == '0) && (out_chan.gain_vertical == '0))
    else $error("nonzero gain on out-of-range lookup");

  // A valid stage-three word is never both a bank write and a lookup.
  a_write_xor_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    s3_ctl.valid |-> !(s3_ctl.write && s3_ctl.lookup))
    else $error("write and lookup in one word");

  // A new result word can only appear when the output register loaded it as the pipeline moved.
  a_rise_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(adv))
    else $error("result appeared during a stall");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the beam gain bilinear lookup
// Writes small gain patches, then looks up points inside, on the edges and
// outside the written area. Every result word is checked field by field
// against a bilinear predictor kept in step with the writes.
// ----------------------------------------------------------------------------
module testbench;
  import bgbl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int THETA_N = 128;
  localparam int PHI_N   = 4096;
  localparam int FB      = 10;
  localparam longint SC  = 64'd1 << FB;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [PHI_IDX_W-1:0]     pidx;
    logic [THETA_IDX_W-1:0]   tidx;
    logic signed [COMP_W-1:0] c1, c2, c3, c4;
    logic signed [THETA_W-1:0] theta;
    logic signed [PHI_W-1:0]  phi;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gh;
    logic [GAIN_W-1:0] gv;
    logic              inr;
  } gain_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bgbl_in_if  in_chan ();
  bgbl_out_if out_chan ();

  beam_gain_bilinear_lookup_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of both grids; only written cells are present.
  longint unsigned grid_h [int];
  longint unsigned grid_v [int];
  // Cells that some queued write will have filled by the time a later word runs.
  bit queued_cells [int];

  cmd_t  pending_words[$];
  gain_t expected_gains[$];
  int    errors = 0;
  int    words_sent = 0;
  int    lookups_sent = 0;
  int    outside_seen = 0;
  int    results_seen = 0;
  bit    hold_go = 0;    // starts the long receiver stall once
  int    hold_cnt = 0;   // cycles of that stall so far
  bit    pause_req = 0;  // sender waits until every result has come
  bit    stim_done = 0;

  function automatic longint unsigned sq(logic signed [COMP_W-1:0] c);
    longint s;
    s = c;
    return s * s;
  endfunction

  function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                          longint unsigned f);
    return (a * (SC - f) + b * f) >> FB;
  endfunction

  // Apply one word to the predictor; a lookup pushes its expected result.
  task automatic predict_word(cmd_t w);
    longint th, ph, it, ip, ft, fp;
    longint unsigned sum, a0, a1, b0, b1;
    int k;
    gain_t g;
    words_sent++;
    if (w.op == OP_WR_H || w.op == OP_WR_V) begin
      sum = sq(w.c1) + sq(w.c2) + sq(w.c3) + sq(w.c4);
      sum &= (64'd1 << GAIN_W) - 1;
      k = int'(w.pidx) * THETA_N + int'(w.tidx);
      if (w.op == OP_WR_H) grid_h[k] = sum;
      else grid_v[k] = sum;
    end else if (w.op == OP_LOOKUP) begin
      lookups_sent++;
      g = '0;
      th = w.theta;
      ph = w.phi;
      if (ph < 0) ph += 3600 * SC;
      if (th >= 0 && ph >= 0) begin
        it = th >>> FB; ip = ph >>> FB;
        ft = th & (SC - 1); fp = ph & (SC - 1);
        if (it + 1 < THETA_N && ip + 1 < PHI_N) begin
          k = int'(ip) * THETA_N + int'(it);
          a0 = grid_h[k]; a1 = grid_h[k+1];
          b0 = grid_h[k+THETA_N]; b1 = grid_h[k+THETA_N+1];
          g.gh = GAIN_W'(mix(mix(a0, a1, ft), mix(b0, b1, ft), fp));
          a0 = grid_v[k]; a1 = grid_v[k+1];
          b0 = grid_v[k+THETA_N]; b1 = grid_v[k+THETA_N+1];
          g.gv = GAIN_W'(mix(mix(a0, a1, ft), mix(b0, b1, ft), fp));
          g.inr = 1'b1;
        end
      end
      if (!g.inr) outside_seen++;
      expected_gains.push_back(g);
    end
  endtask

  // True when a lookup reads no cell, or only cells already queued for writing.
  function automatic bit reads_queued(cmd_t w);
    longint th, ph, it, ip;
    int k;
    th = w.theta;
    ph = w.phi;
    if (ph < 0) ph += 3600 * SC;
    if (th < 0 || ph < 0) return 1;
    it = th >>> FB;
    ip = ph >>> FB;
    if (it + 1 >= THETA_N || ip + 1 >= PHI_N) return 1;
    k = int'(ip) * THETA_N + int'(it);
    return queued_cells.exists(k) && queued_cells.exists(k + 1) &&
           queued_cells.exists(k + THETA_N) && queued_cells.exists(k + THETA_N + 1);
  endfunction

  function automatic cmd_t noise_word();
    cmd_t w;
    w = cmd_t'({$urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic cmd_t write_word(bit vert, int p, int t);
    cmd_t w;
    w = noise_word();
    w.op = vert ? OP_WR_V : OP_WR_H;
    w.pidx = PHI_IDX_W'(p);
    w.tidx = THETA_IDX_W'(t);
    return w;
  endfunction

  // Lookup word; theta/phi are the full fixed-point angles, other fields are random.
  function automatic cmd_t lookup_word(longint th, longint ph);
    cmd_t w;
    w = noise_word();
    w.op = OP_LOOKUP;
    w.theta = THETA_W'(th);
    w.phi = PHI_W'(ph);
    return w;
  endfunction

  // Writes both grids over a rectangle of cells.
  task automatic fill_patch(int p0, int t0, int np, int nt);
    for (int p = p0; p < p0 + np; p++)
      for (int t = t0; t < t0 + nt; t++) begin
        pending_words.push_back(write_word(0, p, t));
        pending_words.push_back(write_word(1, p, t));
        queued_cells[p * THETA_N + t] = 1'b1;
      end
  endtask

  // Lookup anywhere whose four neighbors lie in the patch (p0..,t0..).
  function automatic cmd_t inside_lookup(int p0, int t0, int np, int nt);
    longint th, ph;
    th = longint'($urandom_range(t0, t0 + nt - 2)) * SC + $urandom_range(0, SC - 1);
    ph = longint'($urandom_range(p0, p0 + np - 2)) * SC + $urandom_range(0, SC - 1);
    // Phi rows below 3600 can also be reached from a negative angle.
    if (ph < 3600 * SC && $urandom_range(0, 1)) ph -= 3600 * SC;
    return lookup_word(th, ph);
  endfunction

  // Driver: bursts of random length with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      {in_chan.op, in_chan.cell_phi_index, in_chan.cell_theta_index,
       in_chan.component_one, in_chan.component_two, in_chan.component_three,
       in_chan.component_four, in_chan.theta_angle, in_chan.phi_angle} <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_word(pending_words.pop_front());
      end
      if (in_chan.valid && !in_chan.ready) begin
        // Holding the current word until it is taken.
      end else if (pause_req || pending_words.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_chan.valid <= 1'b0;
      end else begin
        {in_chan.op, in_chan.cell_phi_index, in_chan.cell_theta_index,
         in_chan.component_one, in_chan.component_two, in_chan.component_three,
         in_chan.component_four, in_chan.theta_angle, in_chan.phi_angle}
          <= pending_words[0];
        in_chan.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Counts the cycles of the long receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: checks each result word and drives the receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    gain_t g;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (expected_gains.size() == 0) begin
          $error("result word with no lookup waiting");
          errors++;
        end else begin
          g = expected_gains.pop_front();
          if (out_chan.gain_horizontal !== g.gh) begin
            $error("gain_horizontal: expected %0d, got %0d", g.gh, out_chan.gain_horizontal);
            errors++;
          end
          if (out_chan.gain_vertical !== g.gv) begin
            $error("gain_vertical: expected %0d, got %0d", g.gv, out_chan.gain_vertical);
            errors++;
          end
          if (out_chan.in_range !== g.inr) begin
            $error("in_range: expected %0d, got %0d", g.inr, out_chan.in_range);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 600;
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        out_chan.ready <= 1'b0;
      end else if (stall_phase < 200) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    int p0, t0, np, nt;
    cmd_t w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: patches at grid corners and at phi row 3599, then extreme components.
    fill_patch(0, 0, 2, 2);
    fill_patch(PHI_N - 2, THETA_N - 2, 2, 2);
    fill_patch(3599, 0, 2, 2);
    w = write_word(0, 0, 0);
    w.c1 = 16'sh8000; w.c2 = 16'sh8000; w.c3 = 16'sh8000; w.c4 = 16'sh8000;
    pending_words.push_back(w);                        // largest possible sum
    w.op = OP_WR_V; w.c2 = 16'sh7fff; w.c4 = 16'sh0000;
    pending_words.push_back(w);
    pending_words.push_back(lookup_word(0, 0));        // exact grid point
    pending_words.push_back(lookup_word(SC - 1, SC - 1)); // largest fractions
    pending_words.push_back(lookup_word((THETA_N - 2) * SC + SC - 1,
                                        (PHI_N - 2) * SC + SC - 1));
    pending_words.push_back(lookup_word(SC / 2, -3600 * SC + SC / 2)); // folds onto row 0
    pending_words.push_back(lookup_word((THETA_N - 1) * SC, 0)); // theta past edge
    pending_words.push_back(lookup_word(0, (PHI_N - 1) * SC));   // phi past edge
    pending_words.push_back(lookup_word(-1, 0));                 // negative theta
    pending_words.push_back(lookup_word(-1843200, -3686400));    // theta -1800.0, phi -3600.0
    pending_words.push_back(lookup_word(1843200, 3686400));      // theta +1800.0, phi +3600.0
    pending_words.push_back(lookup_word(0, -1));                 // phi wraps high
    w = noise_word(); w.op = OP_NOP;
    pending_words.push_back(w);
    wait (pending_words.size() == 0 && expected_gains.size() == 0);

    // Long receiver hold-off while the sender keeps offering lookups.
    hold_go = 1;
    repeat (60) pending_words.push_back(lookup_word($urandom_range(0, SC - 1),
                                                    $urandom_range(0, SC - 1)));

    // Random: small patches written, then mostly lookups inside them.
    while (words_sent < 1200) begin
      wait (pending_words.size() < 8);
      if ($urandom_range(0, 7) == 0) begin
        pause_req = 1;
        wait (expected_gains.size() == 0 && !in_chan.valid);
        pause_req = 0;
      end
      np = $urandom_range(2, 4); nt = $urandom_range(2, 4);
      p0 = ($urandom_range(0, 3) == 0) ? PHI_N - np : $urandom_range(0, PHI_N - np);
      t0 = ($urandom_range(0, 3) == 0) ? THETA_N - nt : $urandom_range(0, THETA_N - nt);
      fill_patch(p0, t0, np, nt);
      repeat ($urandom_range(6, 14)) begin
        case ($urandom_range(0, 9))
          0: begin
            w = lookup_word($signed($urandom_range(0, 32'h3fffff) << 10) >>> 10,
                            $signed($urandom_range(0, 32'h7fffff) << 9) >>> 9);
            // A point over cells nobody wrote is moved to negative theta.
            if (!reads_queued(w)) w.theta = ~w.theta;
            pending_words.push_back(w);
          end
          1: begin
            w = noise_word(); w.op = OP_NOP;
            pending_words.push_back(w);
          end
          default: pending_words.push_back(inside_lookup(p0, t0, np, nt));
        endcase
      end
    end
    wait (pending_words.size() == 0);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (expected_gains.size() == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d words with %0d lookups (%0d outside the grid), %0d results checked.",
             words_sent, lookups_sent, outside_seen, results_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

/* beam_gain_bilinear_lookup_top.f */
design/bgbl_pkg.sv
design/bgbl_if.sv
design/bgbl_prep.sv
design/bgbl_bank.sv
design/bgbl_interp.sv
design/beam_gain_bilinear_lookup_top.sv
bench/testbench.sv
